// File: design/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB444 color converter.
package hsv2rgb_pkg;

  localparam int CHANNEL_BITS = 4;
  localparam int CHAN_SHIFT   = 8 - CHANNEL_BITS;
  localparam int LEVEL_BITS   = 17;

  // 1.0 in units of 1/256
  localparam logic [8:0] FULL_SCALE = 9'd256;

  // floor(hue / 360) == (hue * HUE_RECIP) >> HUE_SHIFT for every 16-bit hue
  localparam logic [16:0] HUE_RECIP = 17'd93207;
  localparam int          HUE_SHIFT = 25;

  // floor(n / 15) == (n * DIV15_RECIP) >> DIV15_SHIFT for every 20-bit n
  localparam logic [20:0] DIV15_RECIP = 21'd1118482;
  localparam int          DIV15_SHIFT = 24;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_t;

  typedef struct packed {
    logic [15:0] hue_degrees;
    logic [8:0]  saturation;
    logic [8:0]  brightness;
  } hsv_in_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_out;
    logic [CHANNEL_BITS-1:0] green_out;
    logic [CHANNEL_BITS-1:0] blue_out;
  } rgb_out_t;

  // hue sector, weight of the secondary component, chroma and offset
  typedef struct packed {
    sector_t               sector;
    logic [5:0]            k;
    logic [LEVEL_BITS-1:0] c;
    logic [LEVEL_BITS-1:0] m;
  } hue_t;

  // per-channel level, 16 fractional bits
  typedef struct packed {
    logic [LEVEL_BITS-1:0] r;
    logic [LEVEL_BITS-1:0] g;
    logic [LEVEL_BITS-1:0] b;
  } level_t;

endpackage

// File: design/hsv2rgb_hue.sv
// Front stages: clamp, chroma, hue reduction, sector and secondary weight.
module hsv2rgb_hue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 hsv_valid,
  output logic                 hsv_stall,
  input  hsv2rgb_pkg::hsv_in_t hsv,
  output logic                 hue_valid,
  input  logic                 hue_stall,
  output hsv2rgb_pkg::hue_t    hue
);
  import hsv2rgb_pkg::*;

  logic s1_valid, s2_valid, s3_valid;
  logic ready1, ready2, ready3;

  logic [15:0]           s1_hue;
  logic [7:0]            s1_q;
  logic [LEVEL_BITS-1:0] s1_c;
  logic [8:0]            s1_val;

  logic [8:0]            s2_ang;
  logic [LEVEL_BITS-1:0] s2_c;
  logic [LEVEL_BITS-1:0] s2_m;

  hue_t s3;

  logic [8:0]  sat_c, val_c;
  logic [17:0] c_full;
  logic [32:0] hue_prod;
  logic [15:0] q_deg;
  logic [15:0] ang_full;
  sector_t     sec;
  logic        sec_odd;
  logic [8:0]  sec_base;
  logic [8:0]  rem_full;
  logic [5:0]  rem;
  logic [5:0]  k_next;

  assign ready3    = !s3_valid || !hue_stall;
  assign ready2    = !s2_valid || ready3;
  assign ready1    = !s1_valid || ready2;
  assign hsv_stall = !ready1;

  // stage 1: clamp, chroma product, quotient of hue by 360
  always_comb begin
    sat_c    = (hsv.saturation > FULL_SCALE) ? FULL_SCALE : hsv.saturation;
    val_c    = (hsv.brightness > FULL_SCALE) ? FULL_SCALE : hsv.brightness;
    c_full   = sat_c * val_c;
    hue_prod = hsv.hue_degrees * HUE_RECIP;
  end

  // stage 2: hue mod 360 and offset m
  always_comb begin
    q_deg    = 16'(s1_q) * 16'd360;
    ang_full = s1_hue - q_deg;
  end

  // stage 3: sector and distance into it
  always_comb begin
    if (s2_ang < 9'd60) begin
      sec = SEC_RED_YELLOW;   sec_odd = 1'b0; sec_base = 9'd0;
    end else if (s2_ang < 9'd120) begin
      sec = SEC_YELLOW_GREEN; sec_odd = 1'b1; sec_base = 9'd60;
    end else if (s2_ang < 9'd180) begin
      sec = SEC_GREEN_CYAN;   sec_odd = 1'b0; sec_base = 9'd120;
    end else if (s2_ang < 9'd240) begin
      sec = SEC_CYAN_BLUE;    sec_odd = 1'b1; sec_base = 9'd180;
    end else if (s2_ang < 9'd300) begin
      sec = SEC_BLUE_MAGENTA; sec_odd = 1'b0; sec_base = 9'd240;
    end else begin
      sec = SEC_MAGENTA_RED;  sec_odd = 1'b1; sec_base = 9'd300;
    end
    rem_full = s2_ang - sec_base;
    rem      = rem_full[5:0];
    // rising edge of the secondary in even sectors, falling in odd ones
    k_next   = sec_odd ? (6'd60 - rem) : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (ready1) s1_valid <= hsv_valid;
      if (ready2) s2_valid <= s1_valid;
      if (ready3) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      s1_hue <= hsv.hue_degrees;
      s1_q   <= hue_prod[HUE_SHIFT +: 8];
      s1_c   <= c_full[LEVEL_BITS-1:0];
      s1_val <= val_c;
    end
    if (ready2) begin
      s2_ang <= ang_full[8:0];
      s2_c   <= s1_c;
      s2_m   <= {s1_val, 8'b0} - s1_c;
    end
    if (ready3) begin
      s3.sector <= sec;
      s3.k      <= k_next;
      s3.c      <= s2_c;
      s3.m      <= s2_m;
    end
  end

  assign hue_valid = s3_valid;
  assign hue       = s3;

endmodule

// File: design/hsv2rgb_scale.sv
// Middle stages: secondary component x = c*k/60 and per-channel levels.
module hsv2rgb_scale (
  input  logic                clk,
  input  logic                rst,
  input  logic                hue_valid,
  output logic                hue_stall,
  input  hsv2rgb_pkg::hue_t   hue,
  output logic                lvl_valid,
  input  logic                lvl_stall,
  output hsv2rgb_pkg::level_t lvl
);
  import hsv2rgb_pkg::*;

  logic s4_valid, s5_valid, s6_valid;
  logic ready4, ready5, ready6;

  sector_t               s4_sector, s5_sector;
  logic [LEVEL_BITS-1:0] s4_c, s4_m, s5_c, s5_m;
  logic [21:0]           s4_prod;
  logic [30:0]           s5_pp_hi, s5_pp_lo;
  level_t                s6;

  logic [22:0]           prod_full;
  logic [19:0]           quarter;
  logic [40:0]           recip_sum;
  logic [LEVEL_BITS-1:0] x_val;
  logic [LEVEL_BITS-1:0] r_comp, g_comp, b_comp;

  assign ready6    = !s6_valid || !lvl_stall;
  assign ready5    = !s5_valid || ready6;
  assign ready4    = !s4_valid || ready5;
  assign hue_stall = !ready4;

  assign prod_full = hue.c * hue.k;
  // divide by 60 as a shift by 2 and a reciprocal multiply by 1/15
  assign quarter   = s4_prod[21:2];

  always_comb begin
    recip_sum = {s5_pp_hi, 10'b0} + {10'b0, s5_pp_lo};
    x_val     = recip_sum[DIV15_SHIFT +: LEVEL_BITS];
    case (s5_sector)
      SEC_RED_YELLOW:   begin r_comp = s5_c;  g_comp = x_val; b_comp = '0;    end
      SEC_YELLOW_GREEN: begin r_comp = x_val; g_comp = s5_c;  b_comp = '0;    end
      SEC_GREEN_CYAN:   begin r_comp = '0;    g_comp = s5_c;  b_comp = x_val; end
      SEC_CYAN_BLUE:    begin r_comp = '0;    g_comp = x_val; b_comp = s5_c;  end
      SEC_BLUE_MAGENTA: begin r_comp = x_val; g_comp = '0;    b_comp = s5_c;  end
      default:          begin r_comp = s5_c;  g_comp = '0;    b_comp = x_val; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else begin
      if (ready4) s4_valid <= hue_valid;
      if (ready5) s5_valid <= s4_valid;
      if (ready6) s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4) begin
      s4_sector <= hue.sector;
      s4_c      <= hue.c;
      s4_m      <= hue.m;
      s4_prod   <= prod_full[21:0];
    end
    if (ready5) begin
      s5_sector <= s4_sector;
      s5_c      <= s4_c;
      s5_m      <= s4_m;
      s5_pp_hi  <= quarter[19:10] * DIV15_RECIP;
      s5_pp_lo  <= quarter[9:0] * DIV15_RECIP;
    end
    if (ready6) begin
      s6.r <= r_comp + s5_m;
      s6.g <= g_comp + s5_m;
      s6.b <= b_comp + s5_m;
    end
  end

  assign lvl_valid = s6_valid;
  assign lvl       = s6;

`ifndef ASSERT_OFF
  a_x_below_chroma: assert property (@(posedge clk) disable iff (rst)
    s5_valid |-> x_val <= s5_c)
    else $error("secondary component exceeds chroma");

  a_stage5_advance: assert property (@(posedge clk) disable iff (rst)
    s4_valid && ready5 |=> s5_valid)
    else $error("transaction lost between stages 4 and 5");

  a_stage6_hold: assert property (@(posedge clk) disable iff (rst)
    s6_valid && lvl_stall |=> s6_valid && $stable(s6))
    else $error("stalled level stage changed");
`endif

endmodule

// File: design/hsv2rgb_quant.sv
// Output stage: scale each level by 255 and keep the top channel bits.
module hsv2rgb_quant (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  lvl_valid,
  output logic                  lvl_stall,
  input  hsv2rgb_pkg::level_t   lvl,
  output logic                  rgb_valid,
  input  logic                  rgb_stall,
  output hsv2rgb_pkg::rgb_out_t rgb
);
  import hsv2rgb_pkg::*;

  logic     ready7;
  logic [24:0] r_scaled, g_scaled, b_scaled;
  rgb_out_t rgb_next;

  assign ready7    = !rgb_valid || !rgb_stall;
  assign lvl_stall = !ready7;

  // 255 * level as level * 256 - level
  always_comb begin
    r_scaled = {lvl.r, 8'b0} - {8'b0, lvl.r};
    g_scaled = {lvl.g, 8'b0} - {8'b0, lvl.g};
    b_scaled = {lvl.b, 8'b0} - {8'b0, lvl.b};
    rgb_next.red_out   = r_scaled[16 + CHAN_SHIFT +: CHANNEL_BITS];
    rgb_next.green_out = g_scaled[16 + CHAN_SHIFT +: CHANNEL_BITS];
    rgb_next.blue_out  = b_scaled[16 + CHAN_SHIFT +: CHANNEL_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_valid <= 1'b0;
    end else if (ready7) begin
      rgb_valid <= lvl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready7) rgb <= rgb_next;
  end

endmodule

// File: design/hsv_to_rgb444_converter.sv
// HSV to RGB444 color converter, top level.
// Accepts one pixel per clock while hsv_stall is low; every
// pipeline stage holds its own valid bit, so a stall on the rgb side backs up
// stage by stage without losing or repeating a transaction, and bubbles close
// up. The pipeline stages are the hue reduction (reciprocal multiply, then
// subtract), the sector decode, the chroma-by-weight multiply, the divide by
// 60 split into two reciprocal partial products, the channel select with
// offset add, and the final scale by 255 in the output register.
module hsv_to_rgb444_converter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  hsv_valid,
  output logic                  hsv_stall,
  input  hsv2rgb_pkg::hsv_in_t  hsv,
  output logic                  rgb_valid,
  input  logic                  rgb_stall,
  output hsv2rgb_pkg::rgb_out_t rgb
);
  import hsv2rgb_pkg::*;

  logic   hue_valid, hue_stall;
  hue_t   hue;
  logic   lvl_valid, lvl_stall;
  level_t lvl;

  hsv2rgb_hue u_hue (
    .clk       (clk),
    .rst       (rst),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hsv       (hsv),
    .hue_valid (hue_valid),
    .hue_stall (hue_stall),
    .hue       (hue)
  );

  hsv2rgb_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .hue_valid (hue_valid),
    .hue_stall (hue_stall),
    .hue       (hue),
    .lvl_valid (lvl_valid),
    .lvl_stall (lvl_stall),
    .lvl       (lvl)
  );

  hsv2rgb_quant u_quant (
    .clk       (clk),
    .rst       (rst),
    .lvl_valid (lvl_valid),
    .lvl_stall (lvl_stall),
    .lvl       (lvl),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb)
  );

endmodule
